@@ sv/gap_buffer_text_store_assert.svh @@
// Assertion macros for the gap buffer text store.
`ifndef GAP_BUFFER_TEXT_STORE_ASSERT_SVH
`define GAP_BUFFER_TEXT_STORE_ASSERT_SVH

`ifndef SYNTHESIS
// Checked only while out of reset.
`define GBTS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define GBTS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GBTS_ASSERT(label, clk, rst_n, prop, msg)
`define GBTS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ sv/gbts_pkg.sv @@
package gbts_pkg;

    localparam int DEF_CAPACITY = 1024;

    localparam int FUNC_W  = 3;
    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 10;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 11;

    typedef logic [FUNC_W-1:0] t_func;
    typedef logic [STAT_W-1:0] t_status;

    localparam t_func FN_INSERT = 3'd0;
    localparam t_func FN_LEFT   = 3'd1;
    localparam t_func FN_RIGHT  = 3'd2;
    localparam t_func FN_BACK   = 3'd3;
    localparam t_func FN_DELETE = 3'd4;
    localparam t_func FN_READ   = 3'd5;

    localparam t_status ST_DONE  = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EDGE  = 2'd2;
    localparam t_status ST_RANGE = 2'd3;

endpackage

@@ sv/gap_buffer_text_store.sv @@
// Gap buffer text store.
// Request channel: i_req_valid / o_req_ready carry one operation (func,
// char_in, read_index). Response channel: o_rsp_valid / i_rsp_ready return
// one result per request: status, char_out, text_length, cursor_pos.
// The text sits in one single-port-write, registered-read memory of
// CAPACITY bytes; the cursor (gap start) and gap end are registers.
// Insert, backspace, delete and every refused or edge request finish
// without a memory read: the response is valid the cycle after acceptance,
// and a new request can be taken each cycle that the response is not held.
// Cursor left, cursor right and an in-range read need the memory read
// port: the stored byte comes back in the next cycle (S_RD) and is
// written across the gap (or returned) there; the response is loaded
// from S_RD, and the block takes no request in between.
// The response register holds a result until taken; a new request is
// accepted while it waits only in the cycle that it is taken.
// Synchronous active-low reset empties the text (cursor 0, gap end at
// CAPACITY) and drops any pending response; the memory itself is not
// cleared, and no logical position ever maps to an unwritten entry.
`include "gap_buffer_text_store_assert.svh"

module gap_buffer_text_store #(
    parameter int CAPACITY = gbts_pkg::DEF_CAPACITY
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  logic [gbts_pkg::FUNC_W-1:0]   i_func,
    input  logic [gbts_pkg::CHAR_W-1:0]   i_char_in,
    input  logic [gbts_pkg::INDEX_W-1:0]  i_read_index,
    output logic                          o_rsp_valid,
    input  logic                          i_rsp_ready,
    output logic [gbts_pkg::STAT_W-1:0]   o_status,
    output logic [gbts_pkg::CHAR_W-1:0]   o_char_out,
    output logic [gbts_pkg::COUNT_W-1:0]  o_text_length,
    output logic [gbts_pkg::COUNT_W-1:0]  o_cursor_pos
);
    import gbts_pkg::*;

    localparam int PW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int EW = ((PW > INDEX_W) ? PW : INDEX_W) + 1;
    localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RD   = 1'b1;

    logic              r_state, n_state;
    logic [PW-1:0]     r_gap_start, n_gap_start;
    logic [PW-1:0]     r_gap_stop, n_gap_stop;
    t_func             r_op;
    logic [CHAR_W-1:0] r_rd_data;

    logic              r_rsp_valid;
    t_status           r_status;
    logic [CHAR_W-1:0] r_char_out;
    logic [COUNT_W-1:0] r_text_length;
    logic [COUNT_W-1:0] r_cursor_pos;

    logic [CHAR_W-1:0] mem [CAPACITY];

    logic              w_fire;
    logic [PW-1:0]     w_held;
    logic [PW-1:0]     w_held_next;
    logic [EW-1:0]     w_idx_e;
    logic [EW-1:0]     w_held_e;
    logic [EW-1:0]     w_phys;
    logic [PW+COUNT_W-1:0] w_len_wide;
    logic [PW+COUNT_W-1:0] w_cur_wide;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [CHAR_W-1:0] w_wdata;
    logic              w_re;
    logic [AW-1:0]     w_raddr;
    logic              w_load;
    t_status           w_status;
    logic [CHAR_W-1:0] w_char;

    assign o_req_ready = (r_state == S_IDLE) && (!r_rsp_valid || i_rsp_ready);
    assign w_fire      = i_req_valid && o_req_ready;

    assign w_held   = r_gap_start + (CAP_P - r_gap_stop);
    assign w_idx_e  = {{(EW-INDEX_W){1'b0}}, i_read_index};
    assign w_held_e = {{(EW-PW){1'b0}}, w_held};
    // Positions at or past the cursor skip over the gap.
    assign w_phys   = (w_idx_e < {{(EW-PW){1'b0}}, r_gap_start}) ? w_idx_e
                    : w_idx_e + {{(EW-PW){1'b0}}, r_gap_stop - r_gap_start};

    always_comb begin
        n_state     = r_state;
        n_gap_start = r_gap_start;
        n_gap_stop  = r_gap_stop;
        w_we        = 1'b0;
        w_waddr     = r_gap_start[AW-1:0];
        w_wdata     = i_char_in;
        w_re        = 1'b0;
        w_raddr     = r_gap_stop[AW-1:0];
        w_load      = 1'b0;
        w_status    = ST_DONE;
        w_char      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_fire) begin
                    case (i_func)
                        FN_INSERT: begin
                            w_load = 1'b1;
                            if (r_gap_start >= r_gap_stop) begin
                                w_status = ST_FULL;
                            end else begin
                                w_we        = 1'b1;
                                n_gap_start = r_gap_start + 1'b1;
                            end
                        end
                        FN_LEFT: begin
                            if (r_gap_start == '0) begin
                                w_load   = 1'b1;
                                w_status = ST_EDGE;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = AW'(r_gap_start - 1'b1);
                                n_state = S_RD;
                            end
                        end
                        FN_RIGHT: begin
                            if (r_gap_stop >= CAP_P) begin
                                w_load   = 1'b1;
                                w_status = ST_EDGE;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = r_gap_stop[AW-1:0];
                                n_state = S_RD;
                            end
                        end
                        FN_BACK: begin
                            w_load = 1'b1;
                            if (r_gap_start == '0) begin
                                w_status = ST_EDGE;
                            end else begin
                                n_gap_start = r_gap_start - 1'b1;
                            end
                        end
                        FN_DELETE: begin
                            w_load = 1'b1;
                            if (r_gap_stop >= CAP_P) begin
                                w_status = ST_EDGE;
                            end else begin
                                n_gap_stop = r_gap_stop + 1'b1;
                            end
                        end
                        FN_READ: begin
                            if (w_idx_e >= w_held_e) begin
                                w_load   = 1'b1;
                                w_status = ST_RANGE;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = w_phys[AW-1:0];
                                n_state = S_RD;
                            end
                        end
                        default: begin
                            w_load   = 1'b1;
                            w_status = ST_EDGE;
                        end
                    endcase
                end
            end
            S_RD: begin
                w_load  = 1'b1;
                n_state = S_IDLE;
                w_wdata = r_rd_data;
                case (r_op)
                    FN_LEFT: begin
                        w_we        = 1'b1;
                        w_waddr     = AW'(r_gap_stop - 1'b1);
                        n_gap_start = r_gap_start - 1'b1;
                        n_gap_stop  = r_gap_stop - 1'b1;
                    end
                    FN_RIGHT: begin
                        w_we        = 1'b1;
                        w_waddr     = r_gap_start[AW-1:0];
                        n_gap_start = r_gap_start + 1'b1;
                        n_gap_stop  = r_gap_stop + 1'b1;
                    end
                    FN_READ: begin
                        w_char = r_rd_data;
                    end
                    default: begin
                        w_char = '0;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_held_next = n_gap_start + (CAP_P - n_gap_stop);
    assign w_len_wide  = {{COUNT_W{1'b0}}, w_held_next};
    assign w_cur_wide  = {{COUNT_W{1'b0}}, n_gap_start};

    // Text memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gap_start <= '0;
            r_gap_stop  <= CAP_P;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gap_start <= n_gap_start;
            r_gap_stop  <= n_gap_stop;
            if (w_load) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_op <= i_func;
        end
        if (w_load) begin
            r_status      <= w_status;
            r_char_out    <= w_char;
            r_text_length <= w_len_wide[COUNT_W-1:0];
            r_cursor_pos  <= w_cur_wide[COUNT_W-1:0];
        end
    end

    assign o_rsp_valid   = r_rsp_valid;
    assign o_status      = r_status;
    assign o_char_out    = r_char_out;
    assign o_text_length = r_text_length;
    assign o_cursor_pos  = r_cursor_pos;

    `GBTS_ASSERT(a_gap_order, i_clk, i_rst_n, r_gap_start <= r_gap_stop, "gap start passed gap end")
    `GBTS_ASSERT(a_rd_rsp_free, i_clk, i_rst_n, (r_state == S_RD) |-> !r_rsp_valid, "response register busy during memory access")
    `GBTS_ASSERT(a_insert_step, i_clk, i_rst_n, (w_fire && i_func == FN_INSERT && r_gap_start < r_gap_stop) |=> (r_gap_start == $past(r_gap_start) + 1'b1 && r_gap_stop == $past(r_gap_stop)), "insert did not advance cursor")
    `GBTS_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (r_gap_start == '0 && r_gap_stop == CAP_P && !r_rsp_valid), "reset did not empty the text")

endmodule
